// ----- hw/rtl/qsps_pkg.sv -----
// Shared types, constants and codes for the queued solenoid pulse sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package qsps_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int TURNOUTS    = 4;
   localparam int TABLE_PINS  = 2 * TURNOUTS;

   localparam int PIN_W   = 8;
   localparam int TIME_W  = 16;
   localparam int SLOT_W  = 3;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LVL_W   = 4;
   localparam int WIDE_W  = 64;
   localparam int ADDR_W  = 5;
   localparam int RIDX_W  = 2;

   localparam logic [PIN_W-1:0]  NO_PIN        = 8'hFF;
   localparam logic [TIME_W-1:0] DEFAULT_ON_MS = 16'd10;
   localparam logic              DEFAULT_LEVEL = 1'b1;

   // input opcodes
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // request status codes
   localparam logic [1:0] ST_TICK     = 2'd0;
   localparam logic [1:0] ST_QUEUED   = 2'd1;
   localparam logic [1:0] ST_PRESENT  = 2'd2;
   localparam logic [1:0] ST_REJECTED = 2'd3;

   // phase codes as reported in results
   localparam logic [1:0] PH_IDLE     = 2'd0;
   localparam logic [1:0] PH_ON       = 2'd1;
   localparam logic [1:0] PH_RECHARGE = 2'd2;

   // register indexes
   localparam logic [RIDX_W-1:0] REG_ON_TIMES      = 2'd0;
   localparam logic [RIDX_W-1:0] REG_ACTIVE_LEVELS = 2'd1;
   localparam logic [RIDX_W-1:0] REG_OUTPUT_PINS   = 2'd2;
   localparam logic [RIDX_W-1:0] REG_RECHARGE_MS   = 2'd3;

   typedef struct packed {
      logic             op;
      logic [PIN_W-1:0] pin;
   } req_type;

   typedef struct packed {
      logic             drive_valid;
      logic [PIN_W-1:0] drive_pin;
      logic             drive_level;
      logic [1:0]       request_status;
      logic [SLOT_W-1:0] slot;
      logic [1:0]       phase;
   } rsp_type;

   typedef struct packed {
      logic [WIDE_W-1:0] on_times;
      logic [LVL_W-1:0]  active_levels;
      logic [WIDE_W-1:0] output_pins;
      logic [TIME_W-1:0] recharge_ms;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic       accept;
      logic       start_head;
      logic       end_pulse;
      logic [1:0] phase;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic advance;
      logic rem_zero;
      logic q_nonempty;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/qsps_csr.sv -----
// Configuration registers of the pulse sequencer behind an APB-style port.
// Depends on qsps_pkg.
`default_nettype none

module qsps_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [qsps_pkg::ADDR_W-1:0] paddr,
   input  wire logic [qsps_pkg::WIDE_W-1:0] pwdata,
   output logic      [qsps_pkg::WIDE_W-1:0] prdata,
   output logic                             pready,
   output qsps_pkg::cfg_type                cfg
);
   import qsps_pkg::*;

   cfg_type            cfg_ff;
   cfg_type            cfg_in;
   logic [RIDX_W-1:0]  reg_idx;
   logic               wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_W-1:3];
   assign wr_en   = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ON_TIMES:      cfg_in.on_times      = pwdata;
            REG_ACTIVE_LEVELS: cfg_in.active_levels = pwdata[LVL_W-1:0];
            REG_OUTPUT_PINS:   cfg_in.output_pins   = pwdata;
            REG_RECHARGE_MS:   cfg_in.recharge_ms   = pwdata[TIME_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ON_TIMES:      prdata = cfg_ff.on_times;
         REG_ACTIVE_LEVELS: prdata = {{(WIDE_W-LVL_W){1'b0}}, cfg_ff.active_levels};
         REG_OUTPUT_PINS:   prdata = cfg_ff.output_pins;
         REG_RECHARGE_MS:   prdata = {{(WIDE_W-TIME_W){1'b0}}, cfg_ff.recharge_ms};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_times      <= '0;
         cfg_ff.active_levels <= '1;
         cfg_ff.output_pins   <= '1;
         cfg_ff.recharge_ms   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/qsps_dp.sv -----
// Datapath: pending-pin queue, millisecond down-counter, pin table lookup
// and the result register. Depends on qsps_pkg.
`default_nettype none

module qsps_dp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire qsps_pkg::cfg_type       cfg,
   input  wire qsps_pkg::req_type       req_data,
   input  wire qsps_pkg::ctrl_cmd_type  cmd,
   output qsps_pkg::dp_status_type      status,
   output qsps_pkg::rsp_type            rsp_data
);
   import qsps_pkg::*;

   logic [PIN_W-1:0]  q_ff  [QUEUE_DEPTH];
   logic [PIN_W-1:0]  q_in  [QUEUE_DEPTH];
   logic [PIN_W-1:0]  q_mid [QUEUE_DEPTH];
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_mid;
   logic [TIME_W-1:0] rem_ff, rem_in, rem_dec;
   rsp_type           rsp_ff, rsp_in;

   logic              is_req, hit, full, add;
   logic [QIDX_W-1:0] hit_idx;
   logic [PIN_W-1:0]  head;
   logic [TIME_W-1:0] head_on;
   logic              head_lvl, tmatch;

   // request classification against queued entries
   always_comb begin
      is_req  = (req_data.op == OP_REQUEST);
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (!hit && (CNT_W'(i) < cnt_ff) && (q_ff[i] == req_data.pin)) begin
            hit     = 1'b1;
            hit_idx = QIDX_W'(i);
         end
      end
      full = (cnt_ff == CNT_W'(QUEUE_DEPTH));
      add  = is_req && (req_data.pin != NO_PIN) && !hit && !full;
   end

   // queue with the new pin appended, before any drop
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_mid[i] = (add && (cnt_ff == CNT_W'(i))) ? req_data.pin : q_ff[i];
      end
      cnt_mid = cnt_ff + CNT_W'(add);
      rem_dec = (!is_req && (rem_ff != '0)) ? rem_ff - TIME_W'(1) : rem_ff;
      head    = q_mid[0];
   end

   // first table entry matching the head pin; turnout = entry / 2
   always_comb begin
      tmatch   = 1'b0;
      head_on  = DEFAULT_ON_MS;
      head_lvl = DEFAULT_LEVEL;
      for (int i = 0; i < TABLE_PINS; i++) begin
         if (!tmatch && (cfg.output_pins[8*i +: 8] == head)) begin
            tmatch   = 1'b1;
            head_on  = cfg.on_times[16*(i >> 1) +: 16];
            head_lvl = cfg.active_levels[i >> 1];
         end
      end
   end

   assign status.advance    = !is_req || add;
   assign status.rem_zero   = (rem_dec == '0);
   assign status.q_nonempty = (cnt_mid != '0);

   always_comb begin
      q_in   = q_mid;
      cnt_in = cnt_mid;
      rem_in = rem_dec;
      if (cmd.end_pulse) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_in[i] = q_mid[i+1];
         end
         q_in[QUEUE_DEPTH-1] = '0;
         if (cnt_mid != '0) begin
            cnt_in = cnt_mid - CNT_W'(1);
         end
         rem_in = cfg.recharge_ms;
      end else if (cmd.start_head) begin
         rem_in = head_on;
      end

      rsp_in.drive_valid = cmd.start_head | cmd.end_pulse;
      rsp_in.drive_pin   = (cmd.start_head | cmd.end_pulse) ? head : '0;
      rsp_in.drive_level = cmd.start_head ? head_lvl :
                           cmd.end_pulse  ? ~head_lvl : 1'b0;
      rsp_in.phase       = cmd.phase;
      if (!is_req) begin
         rsp_in.request_status = ST_TICK;
         rsp_in.slot           = '0;
      end else if (hit) begin
         rsp_in.request_status = ST_PRESENT;
         rsp_in.slot           = SLOT_W'(hit_idx);
      end else if (add) begin
         rsp_in.request_status = ST_QUEUED;
         rsp_in.slot           = SLOT_W'(cnt_ff);
      end else begin
         rsp_in.request_status = ST_REJECTED;
         rsp_in.slot           = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rem_ff <= '0;
      end else if (cmd.accept) begin
         cnt_ff <= cnt_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         q_ff   <= q_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/qsps_ctrl.sv -----
// Controller: sequencer phase machine and result handshake.
// Depends on qsps_pkg.
`default_nettype none

module qsps_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire qsps_pkg::dp_status_type status,
   output qsps_pkg::ctrl_cmd_type       cmd
);
   import qsps_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ON,
      S_RECHARGE
   } phase_state_type;

   phase_state_type state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            accept, adv;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign adv       = accept && status.advance;

   always_comb begin
      state_in       = state_ff;
      cmd.accept     = accept;
      cmd.start_head = 1'b0;
      cmd.end_pulse  = 1'b0;
      case (state_ff)
         S_ON: begin
            if (adv && status.rem_zero) begin
               cmd.end_pulse = 1'b1;
               state_in      = S_RECHARGE;
            end
         end
         S_RECHARGE: begin
            if (adv && status.rem_zero) begin
               if (status.q_nonempty) begin
                  cmd.start_head = 1'b1;
                  state_in       = S_ON;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (adv && status.q_nonempty) begin
               cmd.start_head = 1'b1;
               state_in       = S_ON;
            end
         end
         default: state_in = S_IDLE;
      endcase

      case (state_in)
         S_ON:       cmd.phase = PH_ON;
         S_RECHARGE: cmd.phase = PH_RECHARGE;
         default:    cmd.phase = PH_IDLE;
      endcase

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/queued_solenoid_pulse_sequencer.sv -----
// Top level of the queued solenoid pulse sequencer.
// Depends on qsps_pkg, qsps_csr, qsps_ctrl and qsps_dp.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data): each item is either a 1 ms
//    tick (op = tick) or a pulse request for a pin. A request queues the pin
//    in an 8-entry FIFO unless it is already queued, the FIFO is full, or the
//    pin is 255. Ticks count down the current pulse or recharge wait.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data): exactly one result item per
//    request item: the pin level driven in this step (if any), the request
//    status, queue slot, and the sequencer phase after the step.
//  - APB port: on_times (addr 0x00), active_levels (0x08), output_pins
//    (0x10), recharge_ms (0x18), 64-bit data, zero wait states. Write only
//    while the block is idle.
//  - Timing: the result is registered and valid in the cycle after the item is
//    accepted. Throughput: one item per cycle while the receiver takes results;
//    all queue and pin-table compares are done in parallel in combinational
//    logic in the datapath, with one result register at the output.
//  - Receiver stall: the result register holds its item; req_ready stays
//    high while the register is empty or being drained in the same cycle,
//    so a new item can be taken as the old result leaves.
//  - Reset (synchronous): queue empty, phase idle, counter zero, result
//    register empty; on_times 0, active_levels all high, output_pins all
//    255, recharge_ms 0.
`default_nettype none

module queued_solenoid_pulse_sequencer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire qsps_pkg::req_type           req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output qsps_pkg::rsp_type                rsp_data,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [qsps_pkg::ADDR_W-1:0] paddr,
   input  wire logic [qsps_pkg::WIDE_W-1:0] pwdata,
   output logic      [qsps_pkg::WIDE_W-1:0] prdata,
   output logic                             pready
);
   import qsps_pkg::*;

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   qsps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // phase machine and output handshake
   qsps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // queue, counter, lookup, result register
   qsps_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/qsps_checker.sv -----
// Port-level checks for the pulse sequencer, bound to the top level.
// Depends on qsps_pkg and queued_solenoid_pulse_sequencer.
`default_nettype none

module qsps_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire qsps_pkg::rsp_type rsp_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready
);
   import qsps_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // every accepted item yields a result in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after accepted item");

   // undriven steps report pin and level as zero
   a_no_drive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.drive_valid |->
         rsp_data.drive_pin == '0 && !rsp_data.drive_level)
      else $error("drive fields set without drive_valid");

   // ticks and rejections report slot zero; a driven step is never idle
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.request_status == ST_TICK ||
                    rsp_data.request_status == ST_REJECTED) |->
         rsp_data.slot == '0)
      else $error("nonzero slot on tick or rejection");

   a_drive_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.drive_valid |-> rsp_data.phase != PH_IDLE)
      else $error("pin driven but sequencer idle");

endmodule

bind queued_solenoid_pulse_sequencer qsps_checker u_qsps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);

`default_nettype wire
